// ===== rtl/core/ldf_pkg.sv =====
`default_nettype none

package ldf_pkg;

   localparam int LINE_MAX_BYTES_DEF = 32;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_EOL     = 2'd1,
      KIND_TOOLONG = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EMIT = 3'b010,
      ST_EOL  = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic store;
      logic clr_line;
      logic set_disc;
      logic clr_disc;
      logic rd_start;
      logic rd_next;
      logic load_byte;
      logic load_eol;
      logic load_err;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_newline;
      logic discarding;
      logic fill_last;
      logic len_zero;
      logic more;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/ldf_ram.sv =====
`default_nettype none

module ldf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ldf_dpath.sv =====
`default_nettype none

module ldf_dpath
   import ldf_pkg::*;
#(
   parameter int LINE_MAX_BYTES = LINE_MAX_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] req_tdata,
   input  wire logic       rsp_tready,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   output logic            rsp_tvalid,
   output logic [7:0]      rsp_tdata,
   output logic [1:0]      rsp_tuser,
   output logic            rsp_tlast
);

   localparam int CNT_W  = $clog2(LINE_MAX_BYTES + 1);
   localparam int ADDR_W = $clog2(LINE_MAX_BYTES);

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              cr_ff, cr_in;
   logic              disc_ff, disc_in;
   logic [ADDR_W-1:0] rd_ff, rd_in;
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_kind_ff, out_kind_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;

   logic [CNT_W-1:0]  line_len;
   logic [CNT_W-1:0]  rd_plus;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   ldf_ram #(
      .WIDTH (8),
      .DEPTH (LINE_MAX_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // trailing return is dropped from the replayed length
   assign line_len    = fill_ff - CNT_W'(cr_ff);
   assign rd_plus     = CNT_W'(rd_ff) + CNT_W'(1);
   assign ram_rd_en   = cmd.rd_start | cmd.rd_next;
   assign ram_rd_addr = cmd.rd_start ? '0 : rd_plus[ADDR_W-1:0];

   always_comb begin
      sts.in_newline = (req_tdata == CH_NEWLINE);
      sts.discarding = disc_ff;
      sts.fill_last  = (fill_ff == CNT_W'(LINE_MAX_BYTES - 1));
      sts.len_zero   = (line_len == '0);
      sts.more       = (rd_plus < line_len);
      sts.out_free   = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      fill_in = fill_ff;
      cr_in   = cr_ff;
      disc_in = disc_ff;
      rd_in   = rd_ff;
      if (cmd.store) begin
         fill_in = fill_ff + CNT_W'(1);
         cr_in   = (req_tdata == CH_RETURN);
      end
      if (cmd.clr_line) begin
         fill_in = '0;
         cr_in   = 1'b0;
      end
      if (cmd.set_disc) begin
         disc_in = 1'b1;
      end
      if (cmd.clr_disc) begin
         disc_in = 1'b0;
      end
      if (cmd.rd_start) begin
         rd_in = '0;
      end else if (cmd.rd_next) begin
         rd_in = rd_plus[ADDR_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (cmd.load_byte) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_BYTE;
         out_data_in  = ram_rd_data;
         out_last_in  = 1'b0;
      end else if (cmd.load_eol) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_EOL;
         out_data_in  = '0;
         out_last_in  = 1'b1;
      end else if (cmd.load_err) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_TOOLONG;
         out_data_in  = '0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cr_ff        <= 1'b0;
         disc_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cr_ff        <= cr_in;
         disc_ff      <= disc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff       <= rd_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ldf_ctrl.sv =====
`default_nettype none

module ldf_ctrl
   import ldf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   input  wire sts_type sts,
   output logic         req_tready,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sts.discarding) begin
                  cmd.clr_disc = sts.in_newline;
               end else if (sts.in_newline) begin
                  if (sts.len_zero) begin
                     cmd.load_eol = 1'b1;
                     cmd.clr_line = 1'b1;
                  end else begin
                     cmd.rd_start = 1'b1;
                     state_in     = ST_EMIT;
                  end
               end else begin
                  cmd.store = 1'b1;
                  if (sts.fill_last) begin
                     cmd.load_err = 1'b1;
                     cmd.clr_line = 1'b1;
                     cmd.set_disc = 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_byte = 1'b1;
               if (sts.more) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  state_in = ST_EOL;
               end
            end
         end
         ST_EOL: begin
            if (sts.out_free) begin
               cmd.load_eol = 1'b1;
               cmd.clr_line = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/line_deframer_with_overflow_discard.sv =====
// channel  dir  tdata                 tuser                  tlast
// req_     in   [7:0] byte_in         -                      -
// rsp_     out  [7:0] data            [1:0] kind             last
//
// ordinary bytes and empty lines are taken one per cycle
// a newline with len bytes to replay is handled in order: the newline, then one
// byte per cycle from the line memory read port, then the end-of-line word
// req_tready is low during a replay and while an unaccepted result blocks
// the output register; rsp_tready low stalls the replay in place
// reset is synchronous, active high, and clears the line count and flags
`default_nettype none

module line_deframer_with_overflow_discard
   import ldf_pkg::*;
#(
   parameter int LINE_MAX_BYTES = LINE_MAX_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] byte_in
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   ldf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   ldf_dpath #(
      .LINE_MAX_BYTES (LINE_MAX_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // only marker and error words close a byte's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_BYTE)))
      else $error("tlast does not match word kind");

   // a byte filling the line must raise the error next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !sts.discarding && !sts.in_newline && sts.fill_last)
      |=> (rsp_tvalid && rsp_tuser == KIND_TOOLONG && rsp_tlast))
      else $error("missing too-long error");

   // input is only taken when the output register can take a word
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("input taken while output blocked");

   // a newline outside discard starts a replay or gives the marker
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !sts.discarding && sts.in_newline)
      |=> (!req_tready || (rsp_tvalid && rsp_tuser == KIND_EOL)))
      else $error("newline not handled");
`endif

endmodule

`default_nettype wire
